// ===== sv/idst_pkg.sv =====
// Package for the 4x4 inverse DST block: lane and block types, constants,
// the round-and-saturate function and the 4x4 transpose.
// No dependencies.
package idst_pkg;

   localparam int LANE_W    = 16;
   localparam int ROW_W     = 4 * LANE_W;
   localparam int DIFF_W    = LANE_W + 2;
   localparam int ACC_W     = 25;
   localparam int SUM_W     = ACC_W + 1;
   localparam int MUL_A     = 29;
   localparam int MUL_B     = 55;
   localparam int MUL_C     = 74;
   localparam int SHIFT_ONE = 7;
   localparam int SHIFT_TWO = 12;
   localparam int LANE_MAX  = 32767;
   localparam int LANE_MIN  = -32768;

   typedef logic [ROW_W-1:0] row_type;
   typedef logic signed [LANE_W-1:0] lane_type;
   typedef lane_type [15:0] block_type;
   typedef logic signed [ACC_W-1:0] acc_type;
   typedef acc_type [15:0] acc_block_type;

   function automatic lane_type round_sat(input acc_type d, input int unsigned shift);
      logic signed [SUM_W-1:0] t;
      logic signed [SUM_W-1:0] r;
      t = SUM_W'(d) + (SUM_W'(1) <<< (shift - 1));
      r = t >>> shift;
      if (r > SUM_W'(LANE_MAX)) begin
         return lane_type'(LANE_MAX);
      end else if (r < SUM_W'(LANE_MIN)) begin
         return lane_type'(LANE_MIN);
      end
      return lane_type'(r);
   endfunction

   function automatic block_type transpose(input block_type b);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            t[4'(4 * r + k)] = b[4'(4 * k + r)];
         end
      end
      return t;
   endfunction

endpackage

// ===== sv/idst_ifs.sv =====
// Valid/ready channel interfaces for the 4x4 inverse DST block.
// Depends on idst_pkg for the row type.
interface idst_req_if;
   logic              valid;
   logic              ready;
   idst_pkg::row_type coef_row0;
   idst_pkg::row_type coef_row1;
   idst_pkg::row_type coef_row2;
   idst_pkg::row_type coef_row3;
   idst_pkg::row_type skip_row0;
   idst_pkg::row_type skip_row1;
   idst_pkg::row_type skip_row2;
   idst_pkg::row_type skip_row3;

   modport source (output valid, coef_row0, coef_row1, coef_row2, coef_row3,
                   skip_row0, skip_row1, skip_row2, skip_row3, input ready);
   modport sink (input valid, coef_row0, coef_row1, coef_row2, coef_row3,
                 skip_row0, skip_row1, skip_row2, skip_row3, output ready);
endinterface

interface idst_rsp_if;
   logic              valid;
   logic              ready;
   idst_pkg::row_type out_row0;
   idst_pkg::row_type out_row1;
   idst_pkg::row_type out_row2;
   idst_pkg::row_type out_row3;
   logic              last;

   modport source (output valid, out_row0, out_row1, out_row2, out_row3, last,
                   input ready);
   modport sink (input valid, out_row0, out_row1, out_row2, out_row3, last,
                 output ready);
endinterface

// ===== sv/inverse_dst_4x4.sv =====
// Top level of the 4x4 inverse DST block.
// Depends on idst_pkg, idst_ifs (idst_req_if, idst_rsp_if) and idst_pass.
//
// Usage: each transfer on req_if carries one 4x4 coefficient block and one
// 4x4 transform-skip block, four 16-bit lanes per 64-bit row. For each input
// transfer the block makes two transfers on rsp_if: first the skip block
// transposed with last low, then the two-pass inverse DST of the coefficient
// block with last high.
// The second result transfer follows the first in the next cycle when the
// receiver keeps ready high. The single result register shows two result
// transfers per block, and a new input block is taken only when the
// pipeline advances. The five-stage pipeline (input, pass-one products,
// pass-one rounding, pass-two products, result) moves forward as a whole
// whenever the result register is empty or is handing over its last
// transfer.
// Reset: synchronous and active high; it empties every stage, so no result
// is delivered from data taken before reset.
// Stall: while rsp_if.ready is low and a result is valid, it is held and the
// pipeline freezes, so req_if.ready drops and nothing is lost or repeated.
module inverse_dst_4x4 (
   input logic        clock,
   input logic        reset,
   idst_req_if.sink   req_if,
   idst_rsp_if.source rsp_if
);
   import idst_pkg::*;

   logic          advance;
   logic          in_valid_ff;
   logic          prod1_valid_ff;
   logic          mid_valid_ff;
   logic          prod2_valid_ff;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          phase_ff;
   logic          phase_in;
   block_type     coef_ff;
   block_type     skip0_ff;
   block_type     skip1_ff;
   block_type     skip2_ff;
   block_type     skip3_ff;
   block_type     skip_out_ff;
   block_type     mid_ff;
   block_type     mid_in;
   block_type     res_ff;
   block_type     res_in;
   block_type     shown;
   acc_block_type sum1;
   acc_block_type sum2;

   assign advance      = !out_valid_ff || (rsp_if.ready && phase_ff);
   assign req_if.ready = advance;

   idst_pass u_pass_one (
      .clock   (clock),
      .enable  (advance),
      .blk_in  (coef_ff),
      .sum_out (sum1)
   );

   idst_pass u_pass_two (
      .clock   (clock),
      .enable  (advance),
      .blk_in  (mid_ff),
      .sum_out (sum2)
   );

   always_comb begin
      block_type rounded;
      for (int i = 0; i < 16; i++) begin
         rounded[4'(i)] = round_sat(sum1[4'(i)], SHIFT_ONE);
         res_in[4'(i)]  = round_sat(sum2[4'(i)], SHIFT_TWO);
      end
      mid_in = transpose(rounded);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (advance) begin
         out_valid_in = prod2_valid_ff;
         phase_in     = 1'b0;
      end else if (rsp_if.ready) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         prod1_valid_ff <= 1'b0;
         mid_valid_ff   <= 1'b0;
         prod2_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
         phase_ff       <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         if (advance) begin
            in_valid_ff    <= req_if.valid;
            prod1_valid_ff <= in_valid_ff;
            mid_valid_ff   <= prod1_valid_ff;
            prod2_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         coef_ff     <= block_type'({req_if.coef_row3, req_if.coef_row2,
                                     req_if.coef_row1, req_if.coef_row0});
         skip0_ff    <= block_type'({req_if.skip_row3, req_if.skip_row2,
                                     req_if.skip_row1, req_if.skip_row0});
         skip1_ff    <= skip0_ff;
         skip2_ff    <= skip1_ff;
         skip3_ff    <= skip2_ff;
         mid_ff      <= mid_in;
         skip_out_ff <= transpose(skip3_ff);
         res_ff      <= res_in;
      end
   end

   assign shown           = phase_ff ? res_ff : skip_out_ff;
   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.last     = phase_ff;
   assign rsp_if.out_row0 = row_type'(shown[3:0]);
   assign rsp_if.out_row1 = row_type'(shown[7:4]);
   assign rsp_if.out_row2 = row_type'(shown[11:8]);
   assign rsp_if.out_row3 = row_type'(shown[15:12]);

endmodule

// ===== sv/idst_pass.sv =====
// One butterfly pass of the 4x4 inverse DST: registered constant products per
// row, followed by the unrounded output sums. Depends on idst_pkg.
module idst_pass (
   input  logic                    clock,
   input  logic                    enable,
   input  idst_pkg::block_type     blk_in,
   output idst_pkg::acc_block_type sum_out
);
   import idst_pkg::*;

   typedef struct packed {
      acc_type p29s0;
      acc_type p55s1;
      acc_type p74b;
      acc_type p55s2;
      acc_type p29s1;
      acc_type p74e;
      acc_type p55s0;
      acc_type p29s2;
   } prod_type;

   prod_type [3:0] prod_in;
   prod_type [3:0] prod_ff;

   always_comb begin
      lane_type a;
      lane_type b;
      lane_type c;
      lane_type d;
      logic signed [DIFF_W-1:0] s0;
      logic signed [DIFF_W-1:0] s1;
      logic signed [DIFF_W-1:0] s2;
      logic signed [DIFF_W-1:0] e;
      for (int r = 0; r < 4; r++) begin
         a  = blk_in[4'(4 * r)];
         b  = blk_in[4'(4 * r + 1)];
         c  = blk_in[4'(4 * r + 2)];
         d  = blk_in[4'(4 * r + 3)];
         s0 = DIFF_W'(a) + DIFF_W'(c);
         s1 = DIFF_W'(c) + DIFF_W'(d);
         s2 = DIFF_W'(a) - DIFF_W'(d);
         e  = DIFF_W'(a) - DIFF_W'(c) + DIFF_W'(d);
         prod_in[r].p29s0 = ACC_W'(s0) * ACC_W'(MUL_A);
         prod_in[r].p55s1 = ACC_W'(s1) * ACC_W'(MUL_B);
         prod_in[r].p74b  = ACC_W'(b) * ACC_W'(MUL_C);
         prod_in[r].p55s2 = ACC_W'(s2) * ACC_W'(MUL_B);
         prod_in[r].p29s1 = ACC_W'(s1) * ACC_W'(MUL_A);
         prod_in[r].p74e  = ACC_W'(e) * ACC_W'(MUL_C);
         prod_in[r].p55s0 = ACC_W'(s0) * ACC_W'(MUL_B);
         prod_in[r].p29s2 = ACC_W'(s2) * ACC_W'(MUL_A);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum_out[4'(4 * r)]     = prod_ff[r].p29s0 + prod_ff[r].p55s1 + prod_ff[r].p74b;
         sum_out[4'(4 * r + 1)] = prod_ff[r].p55s2 - prod_ff[r].p29s1 + prod_ff[r].p74b;
         sum_out[4'(4 * r + 2)] = prod_ff[r].p74e;
         sum_out[4'(4 * r + 3)] = prod_ff[r].p55s0 + prod_ff[r].p29s2 - prod_ff[r].p74b;
      end
   end

endmodule

// ===== sim/idst_result_check.sv =====
// Checker for the 4x4 inverse DST block: watches both channels, predicts the
// two result transfers of every input transfer and compares them in order.
// Depends on idst_pkg and on idst_req_if and idst_rsp_if from idst_ifs.
module idst_result_check (
   input  logic clock,
   input  logic reset,
   idst_req_if  req_mon,
   idst_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import idst_pkg::*;

   typedef struct packed {
      logic [4*ROW_W-1:0] rows;
      logic               last;
   } rsp_beat_type;

   rsp_beat_type expected_rsp[$];
   int           fails = 0;

   function automatic lane_type clamp_lane(input int v);
      if (v > LANE_MAX) begin
         return lane_type'(LANE_MAX);
      end else if (v < LANE_MIN) begin
         return lane_type'(LANE_MIN);
      end
      return lane_type'(v);
   endfunction

   function automatic block_type swap_axes(input block_type b);
      block_type t;
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            t[4'(4 * r + k)] = b[4'(4 * k + r)];
         end
      end
      return t;
   endfunction

   function automatic block_type dst_rows(input block_type src, input int sh);
      block_type dst;
      int        a, b, c, d, rnd;
      rnd = 1 << (sh - 1);
      for (int y = 0; y < 4; y++) begin
         a = int'($signed(src[4'(4 * y + 0)]));
         b = int'($signed(src[4'(4 * y + 1)]));
         c = int'($signed(src[4'(4 * y + 2)]));
         d = int'($signed(src[4'(4 * y + 3)]));
         dst[4'(4 * y + 0)] =
            clamp_lane((MUL_A * (a + c) + MUL_B * (c + d) + MUL_C * b + rnd) >>> sh);
         dst[4'(4 * y + 1)] =
            clamp_lane((MUL_B * (a - d) - MUL_A * (c + d) + MUL_C * b + rnd) >>> sh);
         dst[4'(4 * y + 2)] =
            clamp_lane((MUL_C * (a - c + d) + rnd) >>> sh);
         dst[4'(4 * y + 3)] =
            clamp_lane((MUL_B * (a + c) + MUL_A * (a - d) - MUL_C * b + rnd) >>> sh);
      end
      return dst;
   endfunction

   always @(posedge clock) begin
      rsp_beat_type got, want;
      block_type    coef, skip;
      logic         bad;
      if (!reset) begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.rows = {rsp_mon.out_row3, rsp_mon.out_row2, rsp_mon.out_row1, rsp_mon.out_row0};
            got.last = rsp_mon.last;
            if (expected_rsp.size() == 0) begin
               $display("%0t: result transfer with nothing expected, rows %h last %b",
                        $time, got.rows, got.last);
               fails++;
            end else begin
               want = expected_rsp.pop_front();
               bad = 1'b0;
               for (int y = 0; y < 4; y++) begin
                  if (got.rows[ROW_W*y +: ROW_W] !== want.rows[ROW_W*y +: ROW_W]) begin
                     $display("%0t: out_row%0d expected %h actual %h", $time, y,
                              want.rows[ROW_W*y +: ROW_W], got.rows[ROW_W*y +: ROW_W]);
                     bad = 1'b1;
                  end
               end
               if (got.last !== want.last) begin
                  $display("%0t: last expected %b actual %b", $time, want.last, got.last);
                  bad = 1'b1;
               end
               if (bad) begin
                  fails++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            coef = {req_mon.coef_row3, req_mon.coef_row2, req_mon.coef_row1, req_mon.coef_row0};
            skip = {req_mon.skip_row3, req_mon.skip_row2, req_mon.skip_row1, req_mon.skip_row0};
            want.rows = swap_axes(skip);
            want.last = 1'b0;
            expected_rsp.push_back(want);
            want.rows = dst_rows(swap_axes(dst_rows(coef, SHIFT_ONE)), SHIFT_TWO);
            want.last = 1'b1;
            expected_rsp.push_back(want);
         end
      end
      fail_count      <= fails;
      pending_results <= expected_rsp.size();
   end

endmodule

// ===== sim/tb_inverse_dst_4x4.sv =====
// Testbench top for the 4x4 inverse DST block: clock, reset, directed and
// random block stimulus under several idle and stall mixes, and the verdict.
// Depends on idst_pkg, idst_ifs, inverse_dst_4x4 and idst_result_check.
module tb_inverse_dst_4x4;
   timeunit 1ns;
   timeprecision 1ps;
   import idst_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 60;

   logic clock;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_results;
   int   send_idle_pct = 0;
   int   rsp_stall_pct = 0;
   int   cycle_count = 0;
   logic holding = 1'b0;
   event hold_start;

   idst_req_if req_ch();
   idst_rsp_if rsp_ch();

   inverse_dst_4x4 dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch.sink),
      .rsp_if (rsp_ch.source)
   );

   idst_result_check u_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !holding && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // The receiver holds off for a fixed stretch so that the pipeline fills.
   initial begin
      forever begin
         @(hold_start);
         holding = 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         holding = 1'b0;
      end
   end

   function automatic lane_type pick_lane();
      int v;
      case ($urandom_range(19))
         0, 1, 2, 3, 4, 5, 6, 7: v = $urandom_range(16'hFFFF);
         8, 9, 10, 11, 12, 13:   v = int'($urandom_range(1024)) - 512;
         14:                     v = LANE_MAX;
         15:                     v = LANE_MIN;
         16:                     v = -1;
         default:                v = 0;
      endcase
      return lane_type'(v);
   endfunction

   function automatic logic [4*ROW_W-1:0] random_coef();
      block_type b;
      for (int i = 0; i < 16; i++) begin
         b[4'(i)] = pick_lane();
      end
      return b;
   endfunction

   function automatic logic [4*ROW_W-1:0] random_skip();
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [4*ROW_W-1:0] fill_lanes(input lane_type v);
      block_type b;
      for (int i = 0; i < 16; i++) begin
         b[4'(i)] = v;
      end
      return b;
   endfunction

   task automatic send_block(input logic [4*ROW_W-1:0] coef, input logic [4*ROW_W-1:0] skip);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.coef_row0 <= coef[0*ROW_W +: ROW_W];
      req_ch.coef_row1 <= coef[1*ROW_W +: ROW_W];
      req_ch.coef_row2 <= coef[2*ROW_W +: ROW_W];
      req_ch.coef_row3 <= coef[3*ROW_W +: ROW_W];
      req_ch.skip_row0 <= skip[0*ROW_W +: ROW_W];
      req_ch.skip_row1 <= skip[1*ROW_W +: ROW_W];
      req_ch.skip_row2 <= skip[2*ROW_W +: ROW_W];
      req_ch.skip_row3 <= skip[3*ROW_W +: ROW_W];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_random(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      repeat (count) send_block(random_coef(), random_skip());
   endtask

   initial begin
      block_type   coef, skip;
      logic [15:0] pattern;
      int          hot [8];

      hot              = '{0, 5, 10, 15, 3, 6, 9, 12};
      req_ch.valid     = 1'b0;
      req_ch.coef_row0 = '0;
      req_ch.coef_row1 = '0;
      req_ch.coef_row2 = '0;
      req_ch.coef_row3 = '0;
      req_ch.skip_row0 = '0;
      req_ch.skip_row1 = '0;
      req_ch.skip_row2 = '0;
      req_ch.skip_row3 = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Distinct skip lanes make any misplaced lane visible.
      for (int i = 0; i < 16; i++) begin
         skip[4'(i)] = lane_type'(i * 16'h1111 + 16'h0102);
      end
      send_block(fill_lanes(16'sh0000), fill_lanes(16'sh0000));
      send_block(fill_lanes(lane_type'(LANE_MAX)), fill_lanes(16'shFFFF));
      send_block(fill_lanes(lane_type'(LANE_MIN)), fill_lanes(16'sh5555));
      send_block(fill_lanes(16'shFFFF), fill_lanes(16'shAAAA));
      send_block(fill_lanes(16'sh0001), skip);
      for (int h = 0; h < 8; h++) begin
         coef = fill_lanes(16'sh0000);
         coef[4'(hot[h])] = (h < 4) ? lane_type'(LANE_MAX) : lane_type'(LANE_MIN);
         send_block(coef, skip);
      end
      foreach (pattern[j]) begin
         if (j < 6) begin
            case (j)
               0:       pattern = 16'h0F0F;
               1:       pattern = 16'h3C3C;
               2:       pattern = 16'hA5A5;
               3:       pattern = 16'h6996;
               4:       pattern = 16'h8421;
               default: pattern = 16'h7BDE;
            endcase
            for (int i = 0; i < 16; i++) begin
               coef[4'(i)] = pattern[4'(i)] ? lane_type'(LANE_MAX) : lane_type'(LANE_MIN);
            end
            send_block(coef, random_skip());
         end
      end

      send_random(140, 0, 0);
      send_random(140, 66, 0);
      send_random(140, 0, 66);
      send_random(140, 15, 15);
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      -> hold_start;
      send_random(60, 0, 0);
      send_random(60, 30, 30);
      -> hold_start;
      send_random(40, 0, 0);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      rsp_stall_pct = 0;
      wait (pending_results == 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/idst_pkg.sv
sv/idst_ifs.sv
sv/idst_pass.sv
sv/inverse_dst_4x4.sv
sim/idst_result_check.sv
sim/tb_inverse_dst_4x4.sv
